@@ hdl/lfrp_pkg.sv @@
// Shared constants for the lightning flash record parser.
// Holds record layout, status codes and parser phase codes; no dependencies.
package lfrp_pkg;

  localparam int MAX_HEADER_RECORDS = 16;
  localparam int RECORD_BYTES       = 28;
  localparam int HEADER_OVERLAP     = 12;

  // Header count kept narrow: only values in 1..MAX_HEADER_RECORDS are ever used
  localparam int HC_W   = $clog2(MAX_HEADER_RECORDS + 1);
  localparam int SKIP_W = $clog2(MAX_HEADER_RECORDS * RECORD_BYTES);

  localparam logic [31:0] HEADER_MARK = 32'h4E4C_444E;

  localparam logic [2:0] ST_RECORD    = 3'd0;
  localparam logic [2:0] ST_NO_FLASH  = 3'd1;
  localparam logic [2:0] ST_CLEAN_END = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_BAD_COUNT = 3'd4;

  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_HCOUNT = 3'd1;
  localparam logic [2:0] PH_FCOUNT = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_FIRST  = 3'd4;
  localparam logic [2:0] PH_BODY   = 3'd5;

  // Byte positions inside a flash record
  localparam logic [4:0] POS_NANO_END = 5'd7;
  localparam logic [4:0] POS_LAT_END  = 5'd11;
  localparam logic [4:0] POS_LON_END  = 5'd15;
  localparam logic [4:0] POS_SIG_END  = 5'd19;
  localparam logic [4:0] POS_MULT     = 5'd22;
  localparam logic [4:0] POS_SEMI     = 5'd24;
  localparam logic [4:0] POS_ECC      = 5'd25;
  localparam logic [4:0] POS_ANGLE    = 5'd26;
  localparam logic [4:0] POS_LAST     = 5'd27;
  localparam logic [4:0] POS_WORD     = 5'd4;

endpackage

@@ hdl/lightning_flash_record_parser.sv @@
// Lightning flash record parser: byte stream in, decoded flash records and status out.
// Depends on lfrp_pkg for layout constants, status and phase codes.
//
//   channel  handshake          payload
//   in       in_valid/in_stall   command, data_byte
//   out      out_valid/out_stall status, flash_seconds .. chi_square
//
// One byte per clock sustained while the result is not stalled; a byte accepted into the
// input register is parsed out of it and its result is offered from the output registers.
// The per-byte state update is the only loop, closed through the parser state registers.
// rst is synchronous and returns the parser to record start with both stages empty.
// A stalled result holds the input register; the input takes a new item once it drains.
module lightning_flash_record_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [7:0]          data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic signed [31:0]  flash_seconds,
  output logic signed [31:0]  flash_nanoseconds,
  output logic signed [31:0]  latitude,
  output logic signed [31:0]  longitude,
  output logic signed [15:0]  signal_strength,
  output logic signed [7:0]   multiplicity,
  output logic signed [7:0]   semimajor_axis,
  output logic signed [7:0]   eccentricity,
  output logic signed [7:0]   ellipse_angle,
  output logic signed [7:0]   chi_square
);
  import lfrp_pkg::*;

  // Input register
  logic       in_q_valid;
  logic       cmd_q;
  logic [7:0] byte_q;

  // Parser state
  logic [2:0]        phase, phase_next;
  logic [4:0]        pos, pos_next;
  logic [SKIP_W-1:0] skip, skip_next;
  logic [31:0]       word_shift, word_shift_next;
  logic [HC_W-1:0]   hcount, hcount_next;
  logic              hcount_ok, hcount_ok_next;
  logic              flashes_present, flashes_present_next;

  // Held record fields
  logic [31:0] held_seconds, held_nanoseconds, held_latitude, held_longitude;
  logic [15:0] held_signal;
  logic [7:0]  held_small [0:3];

  logic        out_blocked;
  logic        advance;
  logic        emit;
  logic        emit_rec;
  logic [2:0]  emit_status;

  logic [31:0]       shifted;
  logic [31:0]       first_word;
  logic [2:0]        first_phase;
  logic [4:0]        first_pos;
  logic [SKIP_W-1:0] skip_dec;
  logic [SKIP_W-1:0] skip_init;

  assign out_blocked = out_valid && out_stall;
  assign in_stall    = in_q_valid && out_blocked;
  assign advance     = in_q_valid && !out_blocked;

  assign shifted   = {word_shift[23:0], byte_q};
  assign skip_dec  = (skip != '0) ? skip - 1'b1 : skip;
  assign skip_init = SKIP_W'(hcount * RECORD_BYTES - HEADER_OVERLAP);

  // Unused phase codes fall back to record start with this byte as the first one
  always_comb begin
    if (phase == PH_START || phase == PH_FIRST) begin
      first_phase = phase;
      first_word  = shifted;
      first_pos   = pos + 1'b1;
    end else begin
      first_phase = PH_START;
      first_word  = {24'd0, byte_q};
      first_pos   = 5'd1;
    end
  end

  always_comb begin
    phase_next           = phase;
    pos_next             = pos;
    skip_next            = skip;
    word_shift_next      = word_shift;
    hcount_next          = hcount;
    hcount_ok_next       = hcount_ok;
    flashes_present_next = flashes_present;
    emit                 = 1'b0;
    emit_rec             = 1'b0;
    emit_status          = ST_RECORD;

    if (cmd_q) begin
      emit            = 1'b1;
      emit_status     = (phase == PH_START && pos == '0) ? ST_CLEAN_END : ST_TRUNCATED;
      phase_next      = PH_START;
      pos_next        = '0;
      skip_next       = '0;
      word_shift_next = '0;
    end else begin
      word_shift_next = shifted;
      unique case (phase)
        PH_HCOUNT: begin
          pos_next = pos + 1'b1;
          if (pos == 5'd3) begin
            hcount_next    = shifted[HC_W-1:0];
            hcount_ok_next = (shifted != '0) && (shifted <= 32'(MAX_HEADER_RECORDS));
            phase_next     = PH_FCOUNT;
            pos_next       = '0;
          end
        end
        PH_FCOUNT: begin
          pos_next = pos + 1'b1;
          if (pos == 5'd3) begin
            flashes_present_next = (shifted != '0);
            pos_next             = '0;
            if (!hcount_ok) begin
              emit            = 1'b1;
              emit_status     = ST_BAD_COUNT;
              phase_next      = PH_START;
              skip_next       = '0;
              word_shift_next = '0;
            end else begin
              skip_next  = skip_init;
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == '0) begin
            pos_next        = '0;
            word_shift_next = '0;
            if (!flashes_present) begin
              emit        = 1'b1;
              emit_status = ST_NO_FLASH;
              phase_next  = PH_START;
            end else begin
              phase_next = PH_FIRST;
            end
          end
        end
        PH_BODY: begin
          pos_next = pos + 1'b1;
          if (pos == POS_LAST) begin
            emit            = 1'b1;
            emit_rec        = 1'b1;
            phase_next      = PH_START;
            pos_next        = '0;
            skip_next       = '0;
            word_shift_next = '0;
          end
        end
        default: begin
          word_shift_next = first_word;
          phase_next      = first_phase;
          pos_next        = first_pos;
          if (first_pos >= POS_WORD) begin
            if (first_phase == PH_START && first_word == HEADER_MARK) begin
              phase_next = PH_HCOUNT;
              pos_next   = '0;
            end else begin
              phase_next = PH_BODY;
              pos_next   = POS_WORD;
            end
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid      <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_START;
      pos             <= '0;
      skip            <= '0;
      word_shift      <= '0;
      hcount          <= '0;
      hcount_ok       <= 1'b0;
      flashes_present <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_q_valid <= in_valid;
      end
      if (advance) begin
        phase           <= phase_next;
        pos             <= pos_next;
        skip            <= skip_next;
        word_shift      <= word_shift_next;
        hcount          <= hcount_next;
        hcount_ok       <= hcount_ok_next;
        flashes_present <= flashes_present_next;
      end
      if (advance && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      cmd_q  <= command;
      byte_q <= data_byte;
    end
    if (advance && !cmd_q) begin
      if ((phase == PH_START || phase == PH_FIRST || phase > PH_BODY) &&
          first_pos >= POS_WORD) begin
        held_seconds <= first_word;
      end
      if (phase == PH_BODY) begin
        case (pos)
          POS_NANO_END: held_nanoseconds <= shifted;
          POS_LAT_END:  held_latitude    <= shifted;
          POS_LON_END:  held_longitude   <= shifted;
          POS_SIG_END:  held_signal      <= shifted[15:0];
          POS_MULT:     held_small[0]    <= byte_q;
          POS_SEMI:     held_small[1]    <= byte_q;
          POS_ECC:      held_small[2]    <= byte_q;
          POS_ANGLE:    held_small[3]    <= byte_q;
          default: ;
        endcase
      end
    end
    if (advance && emit) begin
      status            <= emit_status;
      flash_seconds     <= emit_rec ? held_seconds     : '0;
      flash_nanoseconds <= emit_rec ? held_nanoseconds : '0;
      latitude          <= emit_rec ? held_latitude    : '0;
      longitude         <= emit_rec ? held_longitude   : '0;
      signal_strength   <= emit_rec ? held_signal      : '0;
      multiplicity      <= emit_rec ? held_small[0]    : '0;
      semimajor_axis    <= emit_rec ? held_small[1]    : '0;
      eccentricity      <= emit_rec ? held_small[2]    : '0;
      ellipse_angle     <= emit_rec ? held_small[3]    : '0;
      chi_square        <= emit_rec ? byte_q           : '0;
    end
  end

  a_pos_in_record: assert property (@(posedge clk) disable iff (rst)
    pos < 5'(RECORD_BYTES))
    else $error("byte position past end of record");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip != '0)
    else $error("skip phase with nothing left to skip");

  a_status_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RECORD |-> flash_seconds == '0 && latitude == '0 &&
      chi_square == '0)
    else $error("status result carries nonzero record fields");

  a_hold_on_block: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && out_blocked |=> in_q_valid && $stable(phase) && $stable(pos))
    else $error("parser advanced while result was stalled");

endmodule
